FILE: rtl/deque_with_key_search_core_defines.svh
// ----------------------------------------------------------------------------
// Deque with key search: assertion macros
// Shared assertion macros for the deque core. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_KEY_SEARCH_CORE_DEFINES_SVH
`define DEQUE_WITH_KEY_SEARCH_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Plain property, checked on every rising clock edge outside reset.
`define DQKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Same-cycle implication, checked outside reset.
`define DQKS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define DQKS_ASSERT(lbl, prop, msg)
`define DQKS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/dqks_pkg.sv
// ----------------------------------------------------------------------------
// Deque with key search: package
// Word formats, request and status codes, controller types and helpers.
// ----------------------------------------------------------------------------
package dqks_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int KEY_CHARS_DEFAULT = 8;

  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = 64;
  localparam int LEN_W     = 4;
  localparam int VALUE_W   = 32;
  localparam int REQ_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  localparam logic [7:0] CHAR_UPPER_A     = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z     = 8'h5A;
  localparam logic [7:0] CASE_FOLD_OFFSET = 8'd32;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT,
    REQ_PUSH_BACK,
    REQ_POP_FRONT,
    REQ_POP_BACK,
    REQ_READ_FRONT,
    REQ_READ_BACK,
    REQ_FIND,
    REQ_CLEAR
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_SUCCESS,
    STATUS_FAIL,
    STATUS_FOUND,
    STATUS_NOT_FOUND
  } status_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [KEY_W-1:0]   key_chars;
    logic [LEN_W-1:0]   key_length;
    logic [VALUE_W-1:0] entry_value;
  } req_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  result_value;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RWAIT,
    S_SCAN,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RD_FRONT,
    RD_BACK,
    RD_SCAN
  } rd_sel_t;

  typedef struct packed {
    logic    req_load;
    logic    add_front;
    logic    add_back;
    logic    drop_front;
    logic    drop_back;
    logic    clear;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    scan_clr;
    logic    res_load;
    status_t res_status;
    logic    res_from_mem;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    req_type_t req;
    logic      empty;
    logic      full;
    logic      scan_more;
    logic      hit;
    logic      out_free;
  } dp_status_t;

  // Folds an upper-case ASCII letter to lower case; other bytes pass unchanged.
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_FOLD_OFFSET;
    end
    return c;
  endfunction

endpackage

FILE: rtl/deque_with_key_search_core.sv
// ----------------------------------------------------------------------------
// Deque with key search: top level
// Bounded double-ended queue of keyed entries with case-folded key search.
// ----------------------------------------------------------------------------
//
//   Channel   Word type             Handshake           Direction
//   request   dqks_pkg::req_word_t  req_valid/req_stall into the core
//   response  dqks_pkg::rsp_word_t  rsp_valid/rsp_stall out of the core
//
// A push, pop or clear passes through the execute and done states between
// accepted requests, a read of the front or back also through read-wait, and
// a find through the scan state until a match or the last entry. The states
// follow the entry memory's single registered read port: a search reads one
// entry per cycle, comparing each while the next is being read.
// Reset clears the pointer, occupancy, scan counter and valid flags; the entry
// memory is not cleared, since only slots written by a push are ever read.
// A response waits in an output register; while it is stalled the core holds
// the next result and takes no new request until that register frees up.
//
module deque_with_key_search_core #(
  parameter int DEPTH     = dqks_pkg::DEPTH_DEFAULT,
  parameter int KEY_CHARS = dqks_pkg::KEY_CHARS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  dqks_pkg::req_word_t req_word,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output dqks_pkg::rsp_word_t rsp_word
);
  import dqks_pkg::*;

  // Commands from the controller and status back from the datapath are the
  // only connection between the two halves.
  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences each request: latch it, execute or read, scan
  // for a find, then hand the result to the output register.
  dqks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath owns the entry memory, pointers, scan counter and the
  // registered response word.
  dqks_datapath #(
    .DEPTH     (DEPTH),
    .KEY_CHARS (KEY_CHARS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_word  (req_word),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

endmodule

FILE: rtl/dqks_datapath.sv
// ----------------------------------------------------------------------------
// Deque with key search: datapath
// Entry memory, front pointer, occupancy, scan counter, result and output word.
// ----------------------------------------------------------------------------
`include "deque_with_key_search_core_defines.svh"

module dqks_datapath #(
  parameter int DEPTH     = dqks_pkg::DEPTH_DEFAULT,
  parameter int KEY_CHARS = dqks_pkg::KEY_CHARS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dqks_pkg::req_word_t  req_word,
  input  dqks_pkg::dp_cmd_t    cmd,
  output dqks_pkg::dp_status_t status,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output dqks_pkg::rsp_word_t  rsp_word
);
  import dqks_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [LEN_W-1:0]   len;
    logic [VALUE_W-1:0] value;
  } entry_t;

  req_type_t          req_kind;
  logic [KEY_W-1:0]   req_key;
  logic [LEN_W-1:0]   req_len;
  logic [VALUE_W-1:0] req_value;

  logic [AW-1:0] front;
  logic [CW-1:0] occ;
  logic [CW-1:0] scan_idx;

  entry_t mem [DEPTH];
  entry_t rd_data;
  logic   rd_valid;

  status_t            res_status;
  logic [VALUE_W-1:0] res_value;

  logic [LEN_W-1:0] len_sat;
  logic [KEY_W-1:0] key_in;
  logic [AW-1:0]    front_dec;
  logic [AW-1:0]    front_inc;
  logic [AW-1:0]    back_slot;
  logic [AW-1:0]    last_slot;
  logic [AW-1:0]    scan_slot;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  // Reduces a pointer sum below 2*DEPTH into the slot range.
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    if (s >= SW'(DEPTH)) begin
      return AW'(s - SW'(DEPTH));
    end
    return AW'(s);
  endfunction

  // Keys are stored saturated in length, masked past it and already folded,
  // so a search is a plain equality on length and key bits.
  always_comb begin
    len_sat = (req_word.key_length > LEN_W'(KEY_CHARS)) ? LEN_W'(KEY_CHARS)
                                                        : req_word.key_length;
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_in[8*b +: 8] = (LEN_W'(b) < len_sat) ? fold_char(req_word.key_chars[8*b +: 8])
                                               : 8'h00;
    end
  end

  always_comb begin
    front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
    front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
    back_slot = wrap(SW'(front) + SW'(occ));
    last_slot = wrap(SW'(front) + SW'(occ) - SW'(1));
    scan_slot = wrap(SW'(front) + SW'(scan_idx));
    wr_addr   = cmd.add_front ? front_dec : back_slot;
    unique case (cmd.rd_sel)
      RD_FRONT: rd_addr = front;
      RD_BACK:  rd_addr = last_slot;
      RD_SCAN:  rd_addr = scan_slot;
      default:  rd_addr = front;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.add_front || cmd.add_back) begin
      mem[wr_addr] <= '{key: req_key, len: req_len, value: req_value};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      occ       <= '0;
      scan_idx  <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        front <= '0;
        occ   <= '0;
      end else if (cmd.add_front) begin
        front <= front_dec;
        occ   <= occ + CW'(1);
      end else if (cmd.add_back) begin
        occ <= occ + CW'(1);
      end else if (cmd.drop_front) begin
        front <= front_inc;
        occ   <= occ - CW'(1);
      end else if (cmd.drop_back) begin
        occ <= occ - CW'(1);
      end
      if (cmd.scan_clr) begin
        scan_idx <= '0;
      end else if (cmd.rd_en && cmd.rd_sel == RD_SCAN) begin
        scan_idx <= scan_idx + CW'(1);
      end
      rd_valid <= cmd.rd_en && (cmd.rd_sel == RD_SCAN);
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_kind  <= req_type_t'(req_word.req_type);
      req_key   <= key_in;
      req_len   <= len_sat;
      req_value <= req_word.entry_value;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_value  <= cmd.res_from_mem ? rd_data.value : '0;
    end
    if (cmd.out_load) begin
      rsp_word.status       <= res_status;
      rsp_word.result_value <= res_value;
      rsp_word.entry_count  <= COUNT_W'(occ);
    end
  end

  always_comb begin
    status.req       = req_kind;
    status.empty     = (occ == '0);
    status.full      = (occ == CW'(DEPTH));
    status.scan_more = (scan_idx < occ);
    status.hit       = rd_valid && (rd_data.len == req_len) && (rd_data.key == req_key);
    status.out_free  = !rsp_valid || !rsp_stall;
  end

  `DQKS_ASSERT(a_occ_bound, occ <= CW'(DEPTH), "occupancy above depth")
  `DQKS_ASSERT(a_front_bound, SW'(front) < SW'(DEPTH), "front pointer out of range")
  `DQKS_ASSERT_IMPL(a_push_room, cmd.add_front || cmd.add_back, occ < CW'(DEPTH), "push on full")
  `DQKS_ASSERT_IMPL(a_pop_item, cmd.drop_front || cmd.drop_back, occ != '0, "pop on empty")
  `DQKS_ASSERT_IMPL(a_load_free, cmd.out_load, !rsp_valid || !rsp_stall, "output word overwritten")

endmodule

FILE: rtl/dqks_ctrl.sv
// ----------------------------------------------------------------------------
// Deque with key search: controller
// Sequences one request at a time and drives datapath commands.
// ----------------------------------------------------------------------------
`include "deque_with_key_search_core_defines.svh"

module dqks_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  dqks_pkg::dp_status_t status,
  output dqks_pkg::dp_cmd_t    cmd
);
  import dqks_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.req_load = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status.req)
          REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            cmd.res_load = 1'b1;
            state_next   = S_DONE;
            if (status.full) begin
              cmd.res_status = STATUS_FAIL;
            end else begin
              cmd.res_status = STATUS_SUCCESS;
              cmd.add_front  = (status.req == REQ_PUSH_FRONT);
              cmd.add_back   = (status.req == REQ_PUSH_BACK);
            end
          end
          REQ_POP_FRONT, REQ_POP_BACK: begin
            cmd.res_load = 1'b1;
            state_next   = S_DONE;
            if (status.empty) begin
              cmd.res_status = STATUS_FAIL;
            end else begin
              cmd.res_status = STATUS_SUCCESS;
              cmd.drop_front = (status.req == REQ_POP_FRONT);
              cmd.drop_back  = (status.req == REQ_POP_BACK);
            end
          end
          REQ_READ_FRONT, REQ_READ_BACK: begin
            if (status.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STATUS_FAIL;
              state_next     = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = (status.req == REQ_READ_FRONT) ? RD_FRONT : RD_BACK;
              state_next = S_RWAIT;
            end
          end
          REQ_FIND: begin
            cmd.scan_clr = 1'b1;
            state_next   = S_SCAN;
          end
          REQ_CLEAR: begin
            cmd.clear      = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = STATUS_SUCCESS;
            state_next     = S_DONE;
          end
        endcase
      end
      S_RWAIT: begin
        cmd.res_load     = 1'b1;
        cmd.res_status   = STATUS_SUCCESS;
        cmd.res_from_mem = 1'b1;
        state_next       = S_DONE;
      end
      S_SCAN: begin
        // The compare of one entry overlaps the read of the next.
        if (status.hit) begin
          cmd.res_load     = 1'b1;
          cmd.res_status   = STATUS_FOUND;
          cmd.res_from_mem = 1'b1;
          state_next       = S_DONE;
        end else if (status.scan_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SCAN;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STATUS_NOT_FOUND;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `DQKS_ASSERT_IMPL(a_hit_in_scan, status.hit, state == S_SCAN, "match seen outside a search")
  `DQKS_ASSERT(a_res_then_done, cmd.res_load |=> state == S_DONE, "result not followed by done")
  `DQKS_ASSERT(a_read_wait, cmd.rd_en |=> (state == S_RWAIT || state == S_SCAN), "read data unused")

endmodule

FILE: tb/sv/deque_with_key_search_core_tb.sv
// ----------------------------------------------------------------------------
// Deque with key search: testbench
// Drives request words into the core and checks every response word, field by
// field, against a predictor of the deque kept inside this bench. Directed
// cases come first, then long runs of random requests with random idling on
// both sides, a long response hold-off, and a closing stretch at full rate.
// ----------------------------------------------------------------------------
module deque_with_key_search_core_tb;
  import dqks_pkg::*;

  localparam int DEPTH     = DEPTH_DEFAULT;
  localparam int KEY_CHARS = KEY_CHARS_DEFAULT;
  localparam int POOL_SIZE = 8;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  // Every input of the core holds a known value from time zero.
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req_word  = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp_word;

  // Shadow copy of the deque, advanced once for every accepted request word.
  logic [KEY_W-1:0]   dq_keys [DEPTH];
  logic [LEN_W-1:0]   dq_lens [DEPTH];
  logic [VALUE_W-1:0] dq_vals [DEPTH];
  int dq_front = 0;
  int dq_count = 0;

  // Response words predicted but not yet seen, oldest first.
  rsp_word_t awaited_responses[$];
  rsp_word_t oldest_response;
  int mismatch_count = 0;

  // Random idling on either side, and a long hold-off picked up by the
  // response side when this count is set.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rsp_hold_cycles = 0;

  // A small set of keys, so that random finds hit stored entries often.
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               pool_len [POOL_SIZE];

  deque_with_key_search_core #(
    .DEPTH     (DEPTH),
    .KEY_CHARS (KEY_CHARS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Works out the response to one request word and moves the shadow deque on.
  // Keys are cut to their length first, so bytes past the length never count;
  // a find folds upper-case letters on both sides before comparing.
  function automatic rsp_word_t predict_response(input req_word_t w);
    rsp_word_t        r;
    int               len;
    int               slot;
    bit               same;
    logic [KEY_W-1:0] key;
    logic [7:0]       ca;
    logic [7:0]       cb;
    r = '0;
    r.status = STATUS_SUCCESS;
    len = (w.key_length > KEY_CHARS) ? KEY_CHARS : int'(w.key_length);
    key = (len >= KEY_BYTES) ? w.key_chars
                             : w.key_chars & ((64'd1 << (8 * len)) - 64'd1);
    case (w.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (dq_count >= DEPTH) begin
          r.status = STATUS_FAIL;
        end else begin
          if (w.req_type == REQ_PUSH_FRONT) begin
            dq_front = (dq_front + DEPTH - 1) % DEPTH;
            slot = dq_front;
          end else begin
            slot = (dq_front + dq_count) % DEPTH;
          end
          dq_keys[slot] = key;
          dq_lens[slot] = LEN_W'(len);
          dq_vals[slot] = w.entry_value;
          dq_count++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (dq_count == 0) begin
          r.status = STATUS_FAIL;
        end else begin
          if (w.req_type == REQ_POP_FRONT) begin
            dq_front = (dq_front + 1) % DEPTH;
          end
          dq_count--;
        end
      end
      REQ_READ_FRONT, REQ_READ_BACK: begin
        if (dq_count == 0) begin
          r.status = STATUS_FAIL;
        end else begin
          slot = (w.req_type == REQ_READ_FRONT) ? dq_front
                                                : (dq_front + dq_count - 1) % DEPTH;
          r.result_value = dq_vals[slot];
        end
      end
      REQ_FIND: begin
        r.status = STATUS_NOT_FOUND;
        for (int i = 0; i < dq_count && r.status == STATUS_NOT_FOUND; i++) begin
          slot = (dq_front + i) % DEPTH;
          same = (int'(dq_lens[slot]) == len);
          for (int b = 0; b < len && same; b++) begin
            ca = dq_keys[slot][8*b +: 8];
            cb = key[8*b +: 8];
            if (ca >= CHAR_UPPER_A && ca <= CHAR_UPPER_Z) ca = ca + CASE_FOLD_OFFSET;
            if (cb >= CHAR_UPPER_A && cb <= CHAR_UPPER_Z) cb = cb + CASE_FOLD_OFFSET;
            same = (ca == cb);
          end
          if (same) begin
            r.status = STATUS_FOUND;
            r.result_value = dq_vals[slot];
          end
        end
      end
      default: begin
        dq_count = 0;
        dq_front = 0;
      end
    endcase
    r.entry_count = COUNT_W'(dq_count);
    return r;
  endfunction

  function automatic req_word_t make_req(input req_type_t kind, input logic [KEY_W-1:0] key,
                                         input int len, input logic [VALUE_W-1:0] value);
    req_word_t w;
    w.req_type    = kind;
    w.key_chars   = key;
    w.key_length  = LEN_W'(len);
    w.entry_value = value;
    return w;
  endfunction

  // A request carrying one of the pool keys with its letters in random case and
  // random bytes past the key length. Full-length keys sometimes carry a length
  // above KEY_CHARS, which the core must treat as KEY_CHARS.
  function automatic req_word_t keyed_request(input req_type_t kind);
    req_word_t  w;
    logic [7:0] c;
    int         idx;
    int         n;
    idx = $urandom_range(0, POOL_SIZE - 1);
    n = pool_len[idx];
    w.req_type    = kind;
    w.entry_value = $urandom;
    w.key_chars   = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      c = key_pool[idx][8*i +: 8];
      if ($urandom_range(0, 1) == 1 &&
          ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
           (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z))) begin
        c = c ^ CASE_FOLD_OFFSET;
      end
      w.key_chars[8*i +: 8] = c;
    end
    if (n == KEY_CHARS && $urandom_range(0, 1) == 1) begin
      w.key_length = LEN_W'($urandom_range(KEY_CHARS, 15));
    end else begin
      w.key_length = LEN_W'(n);
    end
    return w;
  endfunction

  // push_pct sets how strongly a stretch leans toward filling the deque; the
  // rest splits into pops, reads, finds and the odd clear. One word in ten
  // gets a fully random key and length.
  function automatic req_word_t random_request(input int push_pct);
    req_word_t w;
    req_type_t kind;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < push_pct) begin
      kind = ($urandom_range(0, 1) == 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        kind = ($urandom_range(0, 1) == 1) ? REQ_POP_BACK : REQ_POP_FRONT;
      end else if (pick < 65) begin
        kind = ($urandom_range(0, 1) == 1) ? REQ_READ_BACK : REQ_READ_FRONT;
      end else if (pick < 97) begin
        kind = REQ_FIND;
      end else begin
        kind = REQ_CLEAR;
      end
    end
    w = keyed_request(kind);
    if ($urandom_range(0, 9) == 0) begin
      w.key_chars  = {$urandom, $urandom};
      w.key_length = LEN_W'($urandom_range(0, 15));
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Offers one request word and holds it until the core takes it. Valid is left
  // high afterwards, so back-to-back words need no second assignment in the
  // same step; an idle gap or a drain lowers it.
  task automatic send_request(input req_word_t w);
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (req_stall);
    awaited_responses.insert(awaited_responses.size(), predict_response(w));
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // The sender pauses until every predicted word has come back, then lets the
  // core settle.
  task automatic wait_for_responses();
    req_valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic init_key_pool();
    for (int k = 0; k < POOL_SIZE; k++) begin
      key_pool[k] = '0;
      pool_len[k] = (k == 0) ? KEY_CHARS : (k == 1) ? 1 : (k == 2) ? 0 :
                    $urandom_range(1, KEY_CHARS);
      for (int i = 0; i < pool_len[k]; i++) begin
        // The last pool key holds arbitrary bytes, high ones included.
        key_pool[k][8*i +: 8] = (k == POOL_SIZE - 1) ? 8'($urandom)
                                : 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
      end
    end
  endtask

  // Empty-deque failures, the field extremes, case folding, letter bounds,
  // saturated and zero lengths, bytes past the length, and a clear.
  task automatic test_directed();
    send_request(make_req(REQ_POP_FRONT, '0, 0, '0));
    send_request(make_req(REQ_POP_BACK, '1, 15, '1));
    send_request(make_req(REQ_READ_FRONT, '0, 0, '0));
    send_request(make_req(REQ_READ_BACK, '0, 0, '0));
    send_request(make_req(REQ_FIND, 64'h6241, 2, '0));
    send_request(make_req(REQ_PUSH_BACK, 64'h6241, 2, 32'hFFFF_FFFF));
    send_request(make_req(REQ_PUSH_FRONT, 64'hFFFF_FFFF_FFFF_FFFF, 8, 32'h0));
    // Key "AZ@[`{az": the neighbors of both letter ranges, length saturated.
    send_request(make_req(REQ_PUSH_BACK, 64'h7A61_7B60_5B40_5A41, 15, 32'h1234_5678));
    send_request(make_req(REQ_PUSH_BACK, 64'hDEAD_BEEF_0BAD_F00D, 0, 32'h1));
    send_request(make_req(REQ_PUSH_FRONT, 64'hC3A5_9E11_0000_7978, 2, 32'h5));
    send_request(make_req(REQ_READ_FRONT, '0, 0, '0));
    send_request(make_req(REQ_READ_BACK, '0, 0, '0));
    send_request(make_req(REQ_FIND, 64'h4241, 2, '0));
    send_request(make_req(REQ_FIND, 64'h0123_4567_89AB_5958, 2, '0));
    send_request(make_req(REQ_FIND, 64'h5555, 0, '0));
    send_request(make_req(REQ_FIND, 64'h5A41_7B60_5B40_7A61, 12, '0));
    // Same letters, but '@' against '`' and '[' against '{' must not fold.
    send_request(make_req(REQ_FIND, 64'h7A61_7B60_7B60_7A61, 8, '0));
    send_request(make_req(REQ_FIND, 64'h6241, 3, '0));
    send_request(make_req(REQ_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 8, '0));
    send_request(make_req(REQ_POP_FRONT, '0, 0, '0));
    send_request(make_req(REQ_POP_BACK, '0, 0, '0));
    send_request(make_req(REQ_READ_FRONT, '0, 0, '0));
    send_request(make_req(REQ_CLEAR, '1, 15, '1));
    send_request(make_req(REQ_READ_BACK, '0, 0, '0));
    send_request(make_req(REQ_PUSH_FRONT, 64'h6B, 1, 32'h7));
    wait_for_responses();
  endtask

  // Fills the deque, pushes into a full one from both ends, scans all slots,
  // wraps the front pointer and empties it again from the back.
  task automatic test_fill_and_wrap();
    send_request(make_req(REQ_CLEAR, '0, 0, '0));
    repeat (DEPTH) send_request(keyed_request(REQ_PUSH_BACK));
    send_request(keyed_request(REQ_PUSH_FRONT));
    send_request(keyed_request(REQ_PUSH_BACK));
    send_request(make_req(REQ_FIND, {$urandom, $urandom}, KEY_CHARS, '0));
    repeat (5) send_request(keyed_request(REQ_FIND));
    repeat (5) send_request(keyed_request(REQ_POP_FRONT));
    repeat (7) send_request(keyed_request(REQ_PUSH_FRONT));
    send_request(keyed_request(REQ_READ_FRONT));
    send_request(keyed_request(REQ_READ_BACK));
    repeat (DEPTH + 1) send_request(keyed_request(REQ_POP_BACK));
    wait_for_responses();
  endtask

  // Stretches that lean toward filling alternate with stretches that lean
  // toward draining, so the deque swings between empty and full.
  task automatic test_random_mix();
    for (int s = 0; s < 22; s++) begin
      repeat (60) send_request(random_request((s % 2 == 0) ? 70 : 20));
    end
  endtask

  // The response side holds off for a long while and the sender keeps
  // offering words, so the core fills up and stalls its request side.
  task automatic test_response_holdoff();
    rsp_hold_cycles = 300;
    repeat (30) send_request(random_request(50));
    wait_for_responses();
  endtask

  task automatic test_full_rate();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int s = 0; s < 4; s++) begin
      repeat (50) send_request(random_request((s % 2 == 0) ? 75 : 15));
    end
  endtask

  // Response side: random stall bursts, and the long hold-off when asked.
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_stall <= 1'b1;
        repeat (rsp_hold_cycles) @(posedge clk);
        rsp_hold_cycles = 0;
        rsp_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 14);
        rsp_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Every response word taken is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response word %h", rsp_word));
      end else begin
        oldest_response = awaited_responses[0];
        awaited_responses.delete(0);
        if (rsp_word.status !== oldest_response.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    rsp_word.status, oldest_response.status));
        end
        if (rsp_word.result_value !== oldest_response.result_value) begin
          report_mismatch($sformatf("result_value %h, expected %h",
                                    rsp_word.result_value, oldest_response.result_value));
        end
        if (rsp_word.entry_count !== oldest_response.entry_count) begin
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    rsp_word.entry_count, oldest_response.entry_count));
        end
      end
    end
  end

  initial begin
    init_key_pool();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_and_wrap();
    test_random_mix();
    test_response_holdoff();
    test_full_rate();
    wait_for_responses();
    if (mismatch_count == 0) begin
      $display("deque_with_key_search_core test passed");
    end else begin
      $display("deque_with_key_search_core test failed");
    end
    $finish;
  end

  // A hung handshake ends the run here; a correct run needs far less time.
  initial begin
    #20000000;
    $display("deque_with_key_search_core test failed");
    $finish;
  end

endmodule

FILE: deque_with_key_search_core.f
+incdir+rtl
rtl/dqks_pkg.sv
rtl/dqks_datapath.sv
rtl/dqks_ctrl.sv
rtl/deque_with_key_search_core.sv
tb/sv/deque_with_key_search_core_tb.sv
